// ----- rtl/core/bta_pkg.sv -----
// shared types, codes and helpers of the boundary-tag heap allocator
// no dependencies; imported by every module of the block
`default_nettype none

package bta_pkg;

    localparam int HEAP_UNITS = 1024;
    localparam int IDX_W      = 11;
    localparam int ADDR_W     = 13;
    localparam int MEM_AW     = 10;
    localparam int ALU_W      = 15;
    localparam int OFF_W      = 13;
    localparam int BYTES_W    = 14;

    localparam logic [IDX_W-1:0] POOL_RESET = IDX_W'(512);
    localparam logic [IDX_W-1:0] POOL_MIN   = IDX_W'(4);
    localparam logic [IDX_W-1:0] POOL_MAX   = IDX_W'(HEAP_UNITS);

    typedef struct packed {
        logic [IDX_W-1:0] size;
        logic             free;
        logic [IDX_W-1:0] prev;
        logic [IDX_W-1:0] pf;
        logic [IDX_W-1:0] nf;
    } hdr_t;

    typedef struct packed {
        logic              rd;
        logic              wr;
        logic              raw;
        logic [ADDR_W-1:0] addr;
        hdr_t              data;
    } mem_req_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_OOM    = 2'd1,
        ST_BAD    = 2'd2,
        ST_DOUBLE = 2'd3
    } status_t;

    typedef struct packed {
        logic             load;
        status_t          status;
        logic [OFF_W-1:0] off;
    } res_t;

    typedef enum logic [2:0] {
        FLD_SIZE,
        FLD_FREE,
        FLD_PREV,
        FLD_PF,
        FLD_NF
    } fld_t;

    typedef enum logic [5:0] {
        S_CLEAR, S_INIT1, S_IDLE, S_OK, S_DONE,
        S_RMW_RD, S_RMW_WR,
        S_I0, S_I1, S_I2, S_I3, S_I4, S_I5, S_I6, S_I7, S_I8, S_I9,
        S_R0, S_R1, S_R2, S_R3, S_R4,
        S_A1, S_A2, S_A3, S_A4, S_A5, S_A6, S_A7, S_A8,
        S_F0, S_F1, S_F1B, S_F2, S_F3, S_F3B, S_F4, S_F5, S_F6, S_F7, S_F7B, S_F8
    } state_t;

    // header index lies inside the live pool
    function automatic logic hdr_valid(logic [ADDR_W-1:0] a, logic [IDX_W-1:0] pool);
        return (a != '0) && (a <= {{(ADDR_W-IDX_W){1'b0}}, pool});
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/bta_alu.sv -----
// shared index adder: a + b + 1, used for unit rounding and block arithmetic
// depends on bta_pkg
`default_nettype none

module bta_alu
    import bta_pkg::*;
(
    input  wire logic [ALU_W-1:0] a,
    input  wire logic [ALU_W-1:0] b,
    output logic      [ALU_W-1:0] sum
);

    assign sum = a + b + ALU_W'(1);

endmodule

`default_nettype wire

// ----- rtl/core/bta_hdr_mem.sv -----
// header store: one write and one registered read per cycle
// out-of-pool reads return zero and out-of-pool writes are dropped unless raw; depends on bta_pkg
`default_nettype none

module bta_hdr_mem
    import bta_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire mem_req_t         req,
    input  wire logic [IDX_W-1:0] pool,
    output hdr_t                  q
);

    hdr_t mem [0:HEAP_UNITS-1];
    hdr_t rd_data_reg;
    logic rd_ok_reg;
    logic ok;

    assign ok = hdr_valid(req.addr, pool);

    always_ff @(posedge clk)
    begin
        if (req.wr && (req.raw || ok))
        begin
            mem[req.addr[MEM_AW-1:0]] <= req.data;
        end
        if (req.rd)
        begin
            rd_data_reg <= mem[req.addr[MEM_AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ok_reg <= 1'b0;
        end
        else if (req.rd)
        begin
            rd_ok_reg <= ok;
        end
    end

    assign q = rd_ok_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

// ----- rtl/core/bta_seq.sv -----
// sequencer: clearing pass, allocate/free walks, list insert/remove, field updates
// depends on bta_pkg; drives bta_hdr_mem and bta_alu
`default_nettype none

module bta_seq
    import bta_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [IDX_W-1:0]   cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               func,
    input  wire logic [BYTES_W-1:0] size_bytes,
    input  wire logic [OFF_W-1:0]   block_offset_in,
    input  wire logic               res_ready,
    output res_t                    res,
    output mem_req_t                mreq,
    input  wire hdr_t               q,
    output logic [IDX_W-1:0]        pool,
    output logic [ALU_W-1:0]        alu_a,
    output logic [ALU_W-1:0]        alu_b,
    input  wire logic [ALU_W-1:0]   alu_sum
);

    state_t             state_reg, state_next;
    state_t             ret_rmw_reg, ret_rmw_next;
    state_t             ret_sub_reg, ret_sub_next;
    logic [ADDR_W-1:0]  rmw_addr_reg, rmw_addr_next;
    fld_t               rmw_fld_reg, rmw_fld_next;
    logic [IDX_W-1:0]   rmw_val_reg, rmw_val_next;
    logic [IDX_W-1:0]   pool_reg, pool_next;
    logic [MEM_AW-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [IDX_W-1:0]   first_reg, first_next;
    logic [IDX_W-1:0]   last_reg, last_next;
    logic               func_reg, func_next;
    logic [IDX_W:0]     units_reg, units_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   steps_reg, steps_next;
    logic [ADDR_W-1:0]  sub_reg, sub_next;
    logic [IDX_W-1:0]   lnx_reg, lnx_next;
    logic [IDX_W-1:0]   lpv_reg, lpv_next;
    logic [IDX_W-1:0]   lsz_reg, lsz_next;
    logic [IDX_W-1:0]   sz_reg, sz_next;
    logic [IDX_W-1:0]   psz_reg, psz_next;
    logic [IDX_W-1:0]   nsz_reg, nsz_next;
    logic [IDX_W-1:0]   p_reg, p_next;
    logic [ADDR_W-1:0]  nxt_reg, nxt_next;
    logic [ADDR_W-1:0]  nn_reg, nn_next;
    status_t            rst_reg, rst_next;
    logic [OFF_W-1:0]   roff_reg, roff_next;
    hdr_t               wdata;
    logic [ADDR_W-1:0]  pool_ext;

    assign pool     = pool_reg;
    assign pool_ext = {{(ADDR_W-IDX_W){1'b0}}, pool_reg};
    assign in_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            ret_rmw_reg <= S_IDLE;
            ret_sub_reg <= S_IDLE;
            pool_reg    <= POOL_RESET;
            clr_cnt_reg <= '0;
            first_reg   <= '0;
            last_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            ret_rmw_reg <= ret_rmw_next;
            ret_sub_reg <= ret_sub_next;
            pool_reg    <= pool_next;
            clr_cnt_reg <= clr_cnt_next;
            first_reg   <= first_next;
            last_reg    <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rmw_addr_reg <= rmw_addr_next;
        rmw_fld_reg  <= rmw_fld_next;
        rmw_val_reg  <= rmw_val_next;
        func_reg     <= func_next;
        units_reg    <= units_next;
        idx_reg      <= idx_next;
        steps_reg    <= steps_next;
        sub_reg      <= sub_next;
        lnx_reg      <= lnx_next;
        lpv_reg      <= lpv_next;
        lsz_reg      <= lsz_next;
        sz_reg       <= sz_next;
        psz_reg      <= psz_next;
        nsz_reg      <= nsz_next;
        p_reg        <= p_next;
        nxt_reg      <= nxt_next;
        nn_reg       <= nn_next;
        rst_reg      <= rst_next;
        roff_reg     <= roff_next;
    end

    // merged entry for a single-field update
    always_comb
    begin
        wdata = q;
        unique case (rmw_fld_reg)
            FLD_SIZE: wdata.size = rmw_val_reg;
            FLD_FREE: wdata.free = rmw_val_reg[0];
            FLD_PREV: wdata.prev = rmw_val_reg;
            FLD_PF:   wdata.pf   = rmw_val_reg;
            FLD_NF:   wdata.nf   = rmw_val_reg;
            default:  wdata      = q;
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        ret_rmw_next  = ret_rmw_reg;
        ret_sub_next  = ret_sub_reg;
        rmw_addr_next = rmw_addr_reg;
        rmw_fld_next  = rmw_fld_reg;
        rmw_val_next  = rmw_val_reg;
        pool_next     = pool_reg;
        clr_cnt_next  = clr_cnt_reg;
        first_next    = first_reg;
        last_next     = last_reg;
        func_next     = func_reg;
        units_next    = units_reg;
        idx_next      = idx_reg;
        steps_next    = steps_reg;
        sub_next      = sub_reg;
        lnx_next      = lnx_reg;
        lpv_next      = lpv_reg;
        lsz_next      = lsz_reg;
        sz_next       = sz_reg;
        psz_next      = psz_reg;
        nsz_next      = nsz_reg;
        p_next        = p_reg;
        nxt_next      = nxt_reg;
        nn_next       = nn_reg;
        rst_next      = rst_reg;
        roff_next     = roff_reg;
        mreq          = '0;
        res           = '0;
        alu_a         = '0;
        alu_b         = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                mreq.wr      = 1'b1;
                mreq.raw     = 1'b1;
                mreq.addr    = ADDR_W'(clr_cnt_reg);
                clr_cnt_next = clr_cnt_reg + MEM_AW'(1);
                if (clr_cnt_reg == MEM_AW'(HEAP_UNITS - 1))
                begin
                    state_next = S_INIT1;
                end
            end
            S_INIT1:
            begin
                mreq.wr        = 1'b1;
                mreq.raw       = 1'b1;
                mreq.addr      = ADDR_W'(1);
                mreq.data.size = pool_reg - IDX_W'(1);
                mreq.data.free = 1'b1;
                first_next     = IDX_W'(1);
                last_next      = IDX_W'(1);
                state_next     = S_IDLE;
            end
            S_IDLE:
            begin
                alu_a = ALU_W'(size_bytes);
                alu_b = ALU_W'(6);
                if (in_valid)
                begin
                    func_next  = func;
                    units_next = alu_sum[ALU_W-1:3];
                    if (!func)
                    begin
                        idx_next   = first_reg;
                        steps_next = '0;
                        state_next = S_A1;
                    end
                    else if ((block_offset_in[2:0] != 3'd0) || (block_offset_in == '0) ||
                             ({1'b0, block_offset_in} >= {pool_reg, 3'b000}))
                    begin
                        rst_next   = ST_BAD;
                        roff_next  = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next   = IDX_W'(block_offset_in[OFF_W-1:3]);
                        state_next = S_F0;
                    end
                end
            end
            S_OK:
            begin
                rst_next   = ST_OK;
                roff_next  = func_reg ? '0 : {idx_reg[MEM_AW-1:0], 3'b000};
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    res.load   = 1'b1;
                    res.status = rst_reg;
                    res.off    = roff_reg;
                    state_next = S_IDLE;
                end
            end

            // single-field update: read, merge, write
            S_RMW_RD:
            begin
                mreq.rd    = 1'b1;
                mreq.addr  = rmw_addr_reg;
                state_next = S_RMW_WR;
            end
            S_RMW_WR:
            begin
                mreq.wr    = 1'b1;
                mreq.addr  = rmw_addr_reg;
                mreq.data  = wdata;
                state_next = ret_rmw_reg;
            end

            // sorted insert of sub_reg
            S_I0:
            begin
                if (!hdr_valid(sub_reg, pool_reg))
                begin
                    state_next = ret_sub_reg;
                end
                else
                begin
                    mreq.rd    = 1'b1;
                    mreq.addr  = sub_reg;
                    state_next = S_I1;
                end
            end
            S_I1:
            begin
                lsz_next   = q.size;
                lnx_next   = first_reg;
                steps_next = '0;
                state_next = S_I2;
            end
            S_I2:
            begin
                if (lnx_reg == '0)
                begin
                    state_next = S_I4;
                end
                else
                begin
                    mreq.rd    = 1'b1;
                    mreq.addr  = ADDR_W'(lnx_reg);
                    state_next = S_I3;
                end
            end
            S_I3:
            begin
                if ((lsz_reg > q.size) && (steps_reg <= pool_reg))
                begin
                    lnx_next   = q.nf;
                    steps_next = steps_reg + IDX_W'(1);
                    state_next = S_I2;
                end
                else
                begin
                    state_next = S_I4;
                end
            end
            S_I4:
            begin
                if (lnx_reg != '0)
                begin
                    mreq.rd    = 1'b1;
                    mreq.addr  = ADDR_W'(lnx_reg);
                    state_next = S_I5;
                end
                else
                begin
                    lpv_next   = last_reg;
                    last_next  = sub_reg[IDX_W-1:0];
                    state_next = S_I6;
                end
            end
            S_I5:
            begin
                lpv_next      = q.pf;
                rmw_addr_next = ADDR_W'(lnx_reg);
                rmw_fld_next  = FLD_PF;
                rmw_val_next  = sub_reg[IDX_W-1:0];
                ret_rmw_next  = S_I6;
                state_next    = S_RMW_RD;
            end
            S_I6:
            begin
                if (lpv_reg != '0)
                begin
                    rmw_addr_next = ADDR_W'(lpv_reg);
                    rmw_fld_next  = FLD_NF;
                    rmw_val_next  = sub_reg[IDX_W-1:0];
                    ret_rmw_next  = S_I7;
                    state_next    = S_RMW_RD;
                end
                else
                begin
                    first_next = sub_reg[IDX_W-1:0];
                    state_next = S_I7;
                end
            end
            S_I7:
            begin
                rmw_addr_next = sub_reg;
                rmw_fld_next  = FLD_PF;
                rmw_val_next  = lpv_reg;
                ret_rmw_next  = S_I8;
                state_next    = S_RMW_RD;
            end
            S_I8:
            begin
                rmw_addr_next = sub_reg;
                rmw_fld_next  = FLD_NF;
                rmw_val_next  = lnx_reg;
                ret_rmw_next  = S_I9;
                state_next    = S_RMW_RD;
            end
            S_I9:
            begin
                rmw_addr_next = sub_reg;
                rmw_fld_next  = FLD_FREE;
                rmw_val_next  = IDX_W'(1);
                ret_rmw_next  = ret_sub_reg;
                state_next    = S_RMW_RD;
            end

            // unlink sub_reg from the free list
            S_R0:
            begin
                if (!hdr_valid(sub_reg, pool_reg))
                begin
                    state_next = ret_sub_reg;
                end
                else
                begin
                    mreq.rd    = 1'b1;
                    mreq.addr  = sub_reg;
                    state_next = S_R1;
                end
            end
            S_R1:
            begin
                lpv_next   = q.pf;
                lnx_next   = q.nf;
                state_next = S_R2;
            end
            S_R2:
            begin
                if (lpv_reg != '0)
                begin
                    rmw_addr_next = ADDR_W'(lpv_reg);
                    rmw_fld_next  = FLD_NF;
                    rmw_val_next  = lnx_reg;
                    ret_rmw_next  = S_R3;
                    state_next    = S_RMW_RD;
                end
                else
                begin
                    first_next = lnx_reg;
                    state_next = S_R3;
                end
            end
            S_R3:
            begin
                if (lnx_reg != '0)
                begin
                    rmw_addr_next = ADDR_W'(lnx_reg);
                    rmw_fld_next  = FLD_PF;
                    rmw_val_next  = lpv_reg;
                    ret_rmw_next  = S_R4;
                    state_next    = S_RMW_RD;
                end
                else
                begin
                    last_next  = lpv_reg;
                    state_next = S_R4;
                end
            end
            S_R4:
            begin
                rmw_addr_next = sub_reg;
                rmw_fld_next  = FLD_FREE;
                rmw_val_next  = '0;
                ret_rmw_next  = ret_sub_reg;
                state_next    = S_RMW_RD;
            end

            // allocate: first fit walk
            S_A1:
            begin
                if (idx_reg == '0)
                begin
                    rst_next   = ST_OOM;
                    roff_next  = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    mreq.rd    = 1'b1;
                    mreq.addr  = ADDR_W'(idx_reg);
                    state_next = S_A2;
                end
            end
            S_A2:
            begin
                if ({1'b0, q.size} < units_reg)
                begin
                    if (steps_reg > pool_reg)
                    begin
                        rst_next   = ST_OOM;
                        roff_next  = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next   = q.nf;
                        steps_next = steps_reg + IDX_W'(1);
                        state_next = S_A1;
                    end
                end
                else
                begin
                    sub_next     = ADDR_W'(idx_reg);
                    ret_sub_next = S_A3;
                    state_next   = S_R0;
                end
            end
            S_A3:
            begin
                mreq.rd    = 1'b1;
                mreq.addr  = ADDR_W'(idx_reg);
                state_next = S_A4;
            end
            S_A4:
            begin
                sz_next = q.size;
                alu_a   = ALU_W'(idx_reg);
                alu_b   = ALU_W'(units_reg);
                if ({2'b00, q.size} >= ({1'b0, units_reg} + (IDX_W+2)'(2)))
                begin
                    nxt_next      = alu_sum[ADDR_W-1:0];
                    rmw_addr_next = alu_sum[ADDR_W-1:0];
                    rmw_fld_next  = FLD_SIZE;
                    rmw_val_next  = q.size - units_reg[IDX_W-1:0] - IDX_W'(1);
                    ret_rmw_next  = S_A5;
                    state_next    = S_RMW_RD;
                end
                else
                begin
                    state_next = S_OK;
                end
            end
            S_A5:
            begin
                alu_a         = ALU_W'(idx_reg);
                alu_b         = ALU_W'(sz_reg);
                nn_next       = alu_sum[ADDR_W-1:0];
                rmw_addr_next = nxt_reg;
                rmw_fld_next  = FLD_PREV;
                rmw_val_next  = idx_reg;
                ret_rmw_next  = S_A6;
                state_next    = S_RMW_RD;
            end
            S_A6:
            begin
                rmw_addr_next = ADDR_W'(idx_reg);
                rmw_fld_next  = FLD_SIZE;
                rmw_val_next  = units_reg[IDX_W-1:0];
                ret_rmw_next  = S_A7;
                state_next    = S_RMW_RD;
            end
            S_A7:
            begin
                sub_next     = nxt_reg;
                ret_sub_next = S_A8;
                state_next   = S_I0;
            end
            S_A8:
            begin
                if (nn_reg <= pool_ext)
                begin
                    rmw_addr_next = nn_reg;
                    rmw_fld_next  = FLD_PREV;
                    rmw_val_next  = nxt_reg[IDX_W-1:0];
                    ret_rmw_next  = S_OK;
                    state_next    = S_RMW_RD;
                end
                else
                begin
                    state_next = S_OK;
                end
            end

            // free: double-free check, merge with neighbours, reinsert
            S_F0:
            begin
                mreq.rd    = 1'b1;
                mreq.addr  = ADDR_W'(idx_reg);
                state_next = S_F1;
            end
            S_F1:
            begin
                alu_a = ALU_W'(idx_reg);
                alu_b = ALU_W'(q.size);
                if (q.free)
                begin
                    rst_next   = ST_DOUBLE;
                    roff_next  = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    sz_next  = q.size;
                    p_next   = q.prev;
                    nxt_next = alu_sum[ADDR_W-1:0];
                    if (idx_reg > IDX_W'(1))
                    begin
                        state_next = S_F1B;
                    end
                    else
                    begin
                        state_next = S_F4;
                    end
                end
            end
            S_F1B:
            begin
                mreq.rd    = 1'b1;
                mreq.addr  = ADDR_W'(p_reg);
                state_next = S_F2;
            end
            S_F2:
            begin
                if (q.free)
                begin
                    psz_next     = q.size;
                    sub_next     = ADDR_W'(p_reg);
                    ret_sub_next = S_F3;
                    state_next   = S_R0;
                end
                else
                begin
                    state_next = S_F4;
                end
            end
            S_F3:
            begin
                alu_a         = ALU_W'(psz_reg);
                alu_b         = ALU_W'(sz_reg);
                rmw_addr_next = ADDR_W'(p_reg);
                rmw_fld_next  = FLD_SIZE;
                rmw_val_next  = alu_sum[IDX_W-1:0];
                ret_rmw_next  = S_F3B;
                state_next    = S_RMW_RD;
            end
            S_F3B:
            begin
                idx_next = p_reg;
                if (nxt_reg <= pool_ext)
                begin
                    rmw_addr_next = nxt_reg;
                    rmw_fld_next  = FLD_PREV;
                    rmw_val_next  = p_reg;
                    ret_rmw_next  = S_F4;
                    state_next    = S_RMW_RD;
                end
                else
                begin
                    state_next = S_F4;
                end
            end
            S_F4:
            begin
                if (nxt_reg <= pool_ext)
                begin
                    mreq.rd    = 1'b1;
                    mreq.addr  = nxt_reg;
                    state_next = S_F5;
                end
                else
                begin
                    state_next = S_F8;
                end
            end
            S_F5:
            begin
                if (q.free)
                begin
                    nsz_next     = q.size;
                    sub_next     = nxt_reg;
                    ret_sub_next = S_F6;
                    state_next   = S_R0;
                end
                else
                begin
                    state_next = S_F8;
                end
            end
            S_F6:
            begin
                mreq.rd    = 1'b1;
                mreq.addr  = ADDR_W'(idx_reg);
                state_next = S_F7;
            end
            S_F7:
            begin
                alu_a         = ALU_W'(q.size);
                alu_b         = ALU_W'(nsz_reg);
                sz_next       = alu_sum[IDX_W-1:0];
                rmw_addr_next = ADDR_W'(idx_reg);
                rmw_fld_next  = FLD_SIZE;
                rmw_val_next  = alu_sum[IDX_W-1:0];
                ret_rmw_next  = S_F7B;
                state_next    = S_RMW_RD;
            end
            S_F7B:
            begin
                alu_a = ALU_W'(idx_reg);
                alu_b = ALU_W'(sz_reg);
                if (alu_sum[ADDR_W-1:0] <= pool_ext)
                begin
                    rmw_addr_next = alu_sum[ADDR_W-1:0];
                    rmw_fld_next  = FLD_PREV;
                    rmw_val_next  = idx_reg;
                    ret_rmw_next  = S_F8;
                    state_next    = S_RMW_RD;
                end
                else
                begin
                    state_next = S_F8;
                end
            end
            S_F8:
            begin
                sub_next     = ADDR_W'(idx_reg);
                ret_sub_next = S_OK;
                state_next   = S_I0;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase

        // pool size write rebuilds the heap
        if (cfg_we)
        begin
            if (cfg_data < POOL_MIN)
            begin
                pool_next = POOL_MIN;
            end
            else if (cfg_data > POOL_MAX)
            begin
                pool_next = POOL_MAX;
            end
            else
            begin
                pool_next = cfg_data;
            end
            clr_cnt_next = '0;
            state_next   = S_CLEAR;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/boundary_tag_heap_allocator.sv -----
// top level of the boundary-tag heap allocator: sequencer, header store, adder, result register
// depends on bta_pkg, bta_alu, bta_hdr_mem and bta_seq
//
// usage
//  - request channel (in_valid/in_stall): func 0 allocates size_bytes rounded up to
//    8-byte units, func 1 frees the block at byte offset block_offset_in
//  - result channel (out_valid/out_stall): one transfer per request carrying status
//    (ok, out of memory, bad address, double free) and the allocated payload offset
//  - pool_units_we/pool_units sets the heap size in units (clamped to 4..1024) and
//    rebuilds the heap as one free block
//  - one request is in flight at a time; in_stall is high from the transfer until
//    the result has been handed to the result register
//  - the single-port header store sets the pace: a rejected request (bad address,
//    double free, empty free list) gives its result without a list walk;
//    otherwise the time grows with each free-list entry walked and each header
//    field update (a read, then a write), growing with list length
//  - after reset and after every pool size write a clearing pass sweeps all 1024
//    headers, one per cycle, then writes the whole-pool block; in_stall is high
//    throughout
//  - a stalled result stays in the output register; the sequencer holds its next
//    result until that register is free
`default_nettype none

module boundary_tag_heap_allocator
    import bta_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               pool_units_we,
    input  wire logic [IDX_W-1:0]   pool_units,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               func,
    input  wire logic [BYTES_W-1:0] size_bytes,
    input  wire logic [OFF_W-1:0]   block_offset_in,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              status,
    output logic [OFF_W-1:0]        block_offset_out
);

    mem_req_t         mreq;
    hdr_t             q;
    logic [IDX_W-1:0] pool;
    logic [ALU_W-1:0] alu_a;
    logic [ALU_W-1:0] alu_b;
    logic [ALU_W-1:0] alu_sum;
    res_t             res;
    logic             res_ready;

    logic             out_valid_reg, out_valid_next;
    logic [1:0]       status_reg, status_next;
    logic [OFF_W-1:0] off_reg, off_next;

    // result register can take a new result when empty or being drained
    assign res_ready = !out_valid_reg || !out_stall;

    bta_seq u_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (pool_units_we),
        .cfg_data        (pool_units),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .func            (func),
        .size_bytes      (size_bytes),
        .block_offset_in (block_offset_in),
        .res_ready       (res_ready),
        .res             (res),
        .mreq            (mreq),
        .q               (q),
        .pool            (pool),
        .alu_a           (alu_a),
        .alu_b           (alu_b),
        .alu_sum         (alu_sum)
    );

    bta_hdr_mem u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .pool  (pool),
        .q     (q)
    );

    bta_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sum (alu_sum)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        off_next       = off_reg;
        if (res.load)
        begin
            out_valid_next = 1'b1;
            status_next    = 2'(res.status);
            off_next       = res.off;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        off_reg    <= off_next;
    end

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign block_offset_out = off_reg;

endmodule

`default_nettype wire
